>>> design/cluster_moment_accumulator_top_defines.svh
// ----------------------------------------------------------------------------
// Cluster moment accumulator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CLUSTER_MOMENT_ACCUMULATOR_TOP_DEFINES_SVH
`define CLUSTER_MOMENT_ACCUMULATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define CMA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cluster moment accumulator assertion failed");

// Next-cycle implication.
`define CMA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cluster moment accumulator assertion failed");

`endif

>>> design/cma_pkg.sv
// ----------------------------------------------------------------------------
// Cluster moment accumulator package
// Widths, codes and the command and status bundles shared by the modules.
// ----------------------------------------------------------------------------
package cma_pkg;

	// Cluster size limit.
	localparam int MAX_BARS = 64;
	localparam int CNT_W    = $clog2(MAX_BARS + 1);
	localparam int LOG_BARS = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;

	// Field widths.
	localparam int E_W        = 16;
	localparam int P_W        = 17;
	localparam int KIND_W     = 2;
	localparam int TE_W       = 22;
	localparam int MOM_W      = 40;
	localparam int BND_W      = P_W + 1;
	localparam int MARGIN_W   = 10;
	localparam int LIMIT_W    = 17;
	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W  = 1;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 224;

	// Per-bar products.
	localparam int EP_W = E_W + P_W + 1;
	localparam int SQ_W = 2 * P_W - 1;
	localparam int R2_W = SQ_W + 2;
	localparam int RL_W = R2_W - P_W;
	localparam int RLP_W = E_W + RL_W;
	localparam int RHP_W = E_W + P_W;

	// Accumulators.
	localparam int ESUM_W = TE_W + LOG_BARS;
	localparam int WS_W   = E_W + P_W + LOG_BARS;
	localparam int RS_W   = 52 + LOG_BARS;

	// Closing arithmetic.
	localparam int NUM_W   = RS_W + 4;
	localparam int T_W     = ESUM_W + P_W + 2;
	localparam int T_LO_W  = T_W - P_W;
	localparam int PLO_W   = P_W + T_LO_W + 1;
	localparam int PHI_W   = 2 * P_W;
	localparam int DVD_W   = RS_W;
	localparam int DCNT_W  = $clog2(DVD_W);

	localparam logic [TE_W-1:0] TE_MAX = {TE_W{1'b1}};

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MARGIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LIMIT   = 1'd1;

	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 10'd60;
	localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 17'd99990;

	// Layer kinds.
	localparam logic [KIND_W-1:0] KIND_Z  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_XY = 2'd1;

	// Divider operand selects.
	localparam logic [1:0] SEL_X   = 2'd0;
	localparam logic [1:0] SEL_Y   = 2'd1;
	localparam logic [1:0] SEL_Z   = 2'd2;
	localparam logic [1:0] SEL_MOM = 2'd3;

	// Controller to datapath commands.
	typedef struct packed {
		logic       load;
		logic       acc;
		logic       div_start;
		logic [1:0] div_sel;
		logic       num_init;
		logic       num_mul_e;
		logic       num_sub;
		logic       num_mul_c;
		logic       num_add;
		logic [1:0] axis;
		logic       res_load;
	} cma_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic last_bar;
		logic e_zero;
		logic multi_bar;
		logic div_done;
		logic out_free;
	} cma_sts_t;

endpackage

>>> design/cluster_moment_accumulator_top.sv
// ----------------------------------------------------------------------------
// Cluster moment accumulator
// Energy-weighted centroid, second moment and range of calorimeter clusters.
// ----------------------------------------------------------------------------
// Bars arrive on the s_axis channel, one per transaction; tlast closes the
// cluster and tuser carries the layer kind. Each bar passes through capture,
// two multiplier stages and the accumulate step; the bar channel is ready
// again right after, unless the bar closes the cluster.
// On the closing bar, the shared 58-step restoring divider forms the three
// centroid coordinates, a short multiply-add sequence builds the moment
// numerator, and the divider runs once more. A single-bar cluster skips the
// numerator and the second division, and a zero total energy skips the divider.
// The result sits in an output register on m_axis; the block keeps taking bars
// while it waits, and only holds the next result until the receiver takes it.
// Configuration (cfg_we, cfg_index, cfg_data) is to be written only while the
// block idles, by the user; the block does not enforce it. Reset clears all
// accumulators and sets the margin to 60 and the open-axis limit to 99990.
// ----------------------------------------------------------------------------
module cluster_moment_accumulator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// bar_energy, pos_x, pos_y, pos_z, zero pad
	input  logic [cma_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                           s_axis_tlast,
	// layer_kind
	input  logic [cma_pkg::KIND_W-1:0]     s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// total_energy, centroid_x, centroid_y, centroid_z, second_moment,
	// x_low, x_high, y_low, y_high, z_low, z_high, zero pad
	output logic [cma_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// range_valid
	output logic                           m_axis_tuser,
	input  logic                           cfg_we,
	input  logic [cma_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cma_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cma_pkg::*;

	cma_cmd_t cmd;
	cma_sts_t sts;

	cma_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	cma_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

>>> design/cma_div.sv
// ----------------------------------------------------------------------------
// Cluster moment accumulator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cma_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cma_pkg::DVD_W-1:0]  dividend,
	input  logic [cma_pkg::ESUM_W-1:0] divisor,
	output logic                       busy,
	output logic                       done,
	output logic [cma_pkg::DVD_W-1:0]  quotient
);
	import cma_pkg::*;

	logic [DVD_W-1:0]  quo_q;
	logic [ESUM_W-1:0] rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ESUM_W:0]   rem_sh;
	logic [ESUM_W+1:0] diff;
	logic              ge;

	// One trial subtraction per cycle.
	always_comb begin
		rem_sh = {rem_q, quo_q[DVD_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, divisor};
		ge     = !diff[ESUM_W+1];
	end

	// Control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift register holds the dividend and collects the quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[ESUM_W-1:0] : rem_sh[ESUM_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> design/cma_ctrl.sv
// ----------------------------------------------------------------------------
// Cluster moment accumulator controller
// Sequences bar accumulation and the closing divisions and moment sum.
// ----------------------------------------------------------------------------
module cma_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  cma_pkg::cma_sts_t sts,
	output cma_pkg::cma_cmd_t cmd
);
	import cma_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MUL1   = 4'd1;
	localparam logic [3:0] S_MUL2   = 4'd2;
	localparam logic [3:0] S_ACC    = 4'd3;
	localparam logic [3:0] S_CSTART = 4'd4;
	localparam logic [3:0] S_CWAIT  = 4'd5;
	localparam logic [3:0] S_NMULE  = 4'd6;
	localparam logic [3:0] S_NSUB   = 4'd7;
	localparam logic [3:0] S_NMULC  = 4'd8;
	localparam logic [3:0] S_NADD   = 4'd9;
	localparam logic [3:0] S_MSTART = 4'd10;
	localparam logic [3:0] S_MWAIT  = 4'd11;
	localparam logic [3:0] S_OUT    = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [1:0] axis_q;
	logic [1:0] axis_d;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		axis_d  = axis_q;
		cmd     = '0;
		cmd.axis    = axis_q;
		cmd.div_sel = axis_q;
		s_axis_tready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL1;
				end
			end
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = S_ACC;
			S_ACC: begin
				cmd.acc = 1'b1;
				axis_d  = SEL_X;
				state_d = sts.last_bar ? S_CSTART : S_IDLE;
			end
			S_CSTART: begin
				if (sts.e_zero) begin
					state_d = S_OUT;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_CWAIT;
				end
			end
			S_CWAIT: begin
				if (sts.div_done) begin
					if (axis_q == SEL_Z) begin
						axis_d = SEL_X;
						if (sts.multi_bar) begin
							cmd.num_init = 1'b1;
							state_d      = S_NMULE;
						end else begin
							state_d = S_OUT;
						end
					end else begin
						axis_d  = axis_q + 1'b1;
						state_d = S_CSTART;
					end
				end
			end
			S_NMULE: begin
				cmd.num_mul_e = 1'b1;
				state_d       = S_NSUB;
			end
			S_NSUB: begin
				cmd.num_sub = 1'b1;
				state_d     = S_NMULC;
			end
			S_NMULC: begin
				cmd.num_mul_c = 1'b1;
				state_d       = S_NADD;
			end
			S_NADD: begin
				cmd.num_add = 1'b1;
				if (axis_q == SEL_Z) begin
					state_d = S_MSTART;
				end else begin
					axis_d  = axis_q + 1'b1;
					state_d = S_NMULE;
				end
			end
			S_MSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = SEL_MOM;
				state_d       = S_MWAIT;
			end
			S_MWAIT: begin
				if (sts.div_done) state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= SEL_X;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
		end
	end

endmodule

>>> design/cma_dp.sv
// ----------------------------------------------------------------------------
// Cluster moment accumulator datapath
// Bar products, cluster sums, centroid and moment arithmetic, result register.
// ----------------------------------------------------------------------------
`include "cluster_moment_accumulator_top_defines.svh"

module cma_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cma_pkg::cma_cmd_t              cmd,
	output cma_pkg::cma_sts_t              sts,
	input  logic [cma_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                           s_axis_tlast,
	input  logic [cma_pkg::KIND_W-1:0]     s_axis_tuser,
	input  logic                           cfg_we,
	input  logic [cma_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cma_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [cma_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tuser
);
	import cma_pkg::*;

	// Input stage.
	logic [E_W-1:0]        e_s1;
	logic signed [P_W-1:0] p_s1 [3];
	logic [KIND_W-1:0]     kind_s1;
	logic                  last_s1;

	// Product stages.
	logic signed [EP_W-1:0] ep_s2 [3];
	logic [SQ_W-1:0]        sq_s2 [3];
	logic [RLP_W-1:0]       rl_s3;
	logic [RHP_W-1:0]       rh_s3;
	logic signed [EP_W-1:0] ep_d [3];
	logic signed [2*P_W-1:0] sq_d [3];
	logic [R2_W-1:0]        r2;

	// Cluster state.
	logic [ESUM_W-1:0]      es_q;
	logic signed [WS_W-1:0] ws_q [3];
	logic [RS_W-1:0]        rs_q;
	logic signed [P_W-1:0]  min_q [3];
	logic signed [P_W-1:0]  max_q [3];
	logic [KIND_W-1:0]      kind_q;
	logic [CNT_W-1:0]       count_q;

	// Closing arithmetic.
	logic signed [P_W-1:0]   c_q [3];
	logic [MOM_W-1:0]        mom_q;
	logic signed [NUM_W-1:0] num_q;
	logic signed [T_W-1:0]   t_q;
	logic signed [PLO_W-1:0] plo_q;
	logic signed [PHI_W-1:0] phi_q;
	logic [1:0]              sel_q;
	logic                    neg_q;
	logic signed [T_W-2:0]   ec_d;
	logic signed [PLO_W-1:0] plo_d;
	logic signed [PHI_W-1:0] phi_d;

	// Divider.
	logic [DVD_W-1:0] dvd;
	logic             div_neg;
	logic             div_busy;
	logic             div_done;
	logic [DVD_W-1:0] div_q;
	logic [WS_W-1:0]  ws_mag;

	// Configuration and result.
	logic [MARGIN_W-1:0]   margin_q;
	logic [LIMIT_W-1:0]    limit_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                  m_tuser_q;
	logic signed [BND_W-1:0] lo_d [3];
	logic signed [BND_W-1:0] hi_d [3];
	logic                  valid_d;
	logic [TE_W-1:0]       te_d;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RESET;
			limit_q  <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RANGE_MARGIN: margin_q <= cfg_data[MARGIN_W-1:0];
				CFG_OPEN_LIMIT:   limit_q  <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the bar on each accepted transaction.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e_s1    <= s_axis_tdata[E_W-1:0];
			p_s1[0] <= s_axis_tdata[E_W+P_W-1:E_W];
			p_s1[1] <= s_axis_tdata[E_W+2*P_W-1:E_W+P_W];
			p_s1[2] <= s_axis_tdata[E_W+3*P_W-1:E_W+2*P_W];
			kind_s1 <= s_axis_tuser;
			last_s1 <= s_axis_tlast;
		end
	end

	// Energy-weighted positions and squared coordinates.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ep_d[k] = $signed({1'b0, e_s1}) * p_s1[k];
			sq_d[k] = p_s1[k] * p_s1[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			ep_s2[k] <= ep_d[k];
			sq_s2[k] <= sq_d[k][SQ_W-1:0];
		end
	end

	// Energy times squared radius, split in two partial products.
	assign r2 = {2'b00, sq_s2[0]} + {2'b00, sq_s2[1]} + {2'b00, sq_s2[2]};

	always_ff @(posedge clk) begin
		rl_s3 <= e_s1 * r2[RL_W-1:0];
		rh_s3 <= e_s1 * r2[R2_W-1:RL_W];
	end

	// Closing products.
	always_comb begin
		ec_d  = $signed({1'b0, es_q}) * c_q[cmd.axis];
		plo_d = c_q[cmd.axis] * $signed({1'b0, t_q[T_LO_W-1:0]});
		phi_d = c_q[cmd.axis] * $signed(t_q[T_W-1:T_LO_W]);
	end

	// Divider operand: weighted sum magnitude or moment numerator.
	always_comb begin
		ws_mag  = ws_q[cmd.div_sel[1:0] == SEL_MOM ? 2'd0 : cmd.div_sel];
		div_neg = ws_mag[WS_W-1];
		if (div_neg) ws_mag = -ws_mag;
		if (cmd.div_sel == SEL_MOM) begin
			dvd     = num_q[DVD_W-1:0];
			div_neg = 1'b0;
		end else begin
			dvd = {{(DVD_W-WS_W){1'b0}}, ws_mag};
		end
	end

	cma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (es_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	// Cluster accumulators, centroid and moment registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			es_q    <= '0;
			rs_q    <= '0;
			kind_q  <= KIND_Z;
			count_q <= '0;
			mom_q   <= '0;
			sel_q   <= SEL_X;
			neg_q   <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				ws_q[k]  <= '0;
				min_q[k] <= {1'b0, {(P_W-1){1'b1}}};
				max_q[k] <= {1'b1, {(P_W-1){1'b0}}};
				c_q[k]   <= '0;
			end
		end else if (cmd.res_load) begin
			es_q    <= '0;
			rs_q    <= '0;
			kind_q  <= KIND_Z;
			count_q <= '0;
			mom_q   <= '0;
			for (int k = 0; k < 3; k++) begin
				ws_q[k]  <= '0;
				min_q[k] <= {1'b0, {(P_W-1){1'b1}}};
				max_q[k] <= {1'b1, {(P_W-1){1'b0}}};
				c_q[k]   <= '0;
			end
		end else begin
			if (cmd.acc && count_q < CNT_W'(MAX_BARS)) begin
				if (count_q == '0) kind_q <= kind_s1;
				es_q <= es_q + {{(ESUM_W-E_W){1'b0}}, e_s1};
				rs_q <= rs_q + {{(RS_W-RLP_W){1'b0}}, rl_s3}
					+ ({{(RS_W-RHP_W){1'b0}}, rh_s3} << RL_W);
				for (int k = 0; k < 3; k++) begin
					ws_q[k] <= ws_q[k] + {{(WS_W-EP_W){ep_s2[k][EP_W-1]}}, ep_s2[k]};
					if (p_s1[k] < min_q[k]) min_q[k] <= p_s1[k];
					if (p_s1[k] > max_q[k]) max_q[k] <= p_s1[k];
				end
				count_q <= count_q + 1'b1;
			end
			if (cmd.div_start) begin
				sel_q <= cmd.div_sel;
				neg_q <= div_neg;
			end
			if (div_done) begin
				if (sel_q == SEL_MOM) begin
					mom_q <= div_q[MOM_W-1:0];
				end else begin
					c_q[sel_q] <= neg_q ? -$signed(div_q[P_W-1:0])
						: $signed(div_q[P_W-1:0]);
				end
			end
		end
	end

	// Moment numerator: radius sum plus c*(E*c - 2*s) per axis.
	always_ff @(posedge clk) begin
		if (cmd.num_init) num_q <= $signed({{(NUM_W-RS_W){1'b0}}, rs_q});
		if (cmd.num_mul_e) t_q <= {ec_d[T_W-2], ec_d};
		if (cmd.num_sub) begin
			t_q <= t_q - ({{(T_W-WS_W){ws_q[cmd.axis][WS_W-1]}}, ws_q[cmd.axis]} <<< 1);
		end
		if (cmd.num_mul_c) begin
			plo_q <= plo_d;
			phi_q <= phi_d;
		end
		if (cmd.num_add) begin
			num_q <= num_q + {{(NUM_W-PLO_W){plo_q[PLO_W-1]}}, plo_q}
				+ ({{(NUM_W-PHI_W){phi_q[PHI_W-1]}}, phi_q} <<< T_LO_W);
		end
	end

	// Range bounds from the first bar's layer kind.
	always_comb begin
		valid_d = (kind_q == KIND_Z) || (kind_q == KIND_XY);
		te_d    = (es_q > {{(ESUM_W-TE_W){1'b0}}, TE_MAX}) ? TE_MAX : es_q[TE_W-1:0];
		for (int k = 0; k < 3; k++) begin
			if (!valid_d) begin
				lo_d[k] = '0;
				hi_d[k] = '0;
			end else if ((kind_q == KIND_Z) ? (k == 2) : (k != 2)) begin
				lo_d[k] = {min_q[k][P_W-1], min_q[k]}
					- $signed({{(BND_W-MARGIN_W){1'b0}}, margin_q});
				hi_d[k] = {max_q[k][P_W-1], max_q[k]}
					+ $signed({{(BND_W-MARGIN_W){1'b0}}, margin_q});
			end else begin
				lo_d[k] = -$signed({1'b0, limit_q});
				hi_d[k] = $signed({1'b0, limit_q});
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			m_tdata_q <= {3'b000, hi_d[2], lo_d[2], hi_d[1], lo_d[1], hi_d[0], lo_d[0],
				mom_q, c_q[2], c_q[1], c_q[0], te_d};
			m_tuser_q <= valid_d;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

	// Status.
	assign sts.last_bar  = last_s1;
	assign sts.e_zero    = (es_q == '0);
	assign sts.multi_bar = (count_q > CNT_W'(1));
	assign sts.div_done  = div_done;
	assign sts.out_free  = !m_tvalid_q || m_axis_tready;

	`CMA_ASSERT_IMP(a_res_free, cmd.res_load, !m_tvalid_q || m_axis_tready)
	`CMA_ASSERT_NXT(a_res_clear, cmd.res_load, es_q == '0 && count_q == '0 && m_tvalid_q)
	`CMA_ASSERT_IMP(a_count_cap, 1'b1, count_q <= CNT_W'(MAX_BARS))
	`CMA_ASSERT_IMP(a_div_idle, cmd.div_start, !div_busy && !cmd.acc)

endmodule
